// ----- rtl/cfps_pkg.sv -----
package cfps_pkg;

  // map geometry
  localparam int MapWidth  = 64;
  localparam int MapHeight = 64;

  // counter widths
  localparam int ColW = (MapWidth > 1) ? $clog2(MapWidth) : 1;
  localparam int RowW = $clog2(MapHeight + 1);

  // beat kinds on the sample channel
  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] pixel_value;
  } sample_t;

  typedef struct packed {
    logic [7:0] smoothed_value;
    logic       frame_end;
  } result_t;

  // floor((floor((l+t+r+b)/4)+c)/2)
  function automatic logic [7:0] blend(input logic [7:0] l, input logic [7:0] t,
                                       input logic [7:0] r, input logic [7:0] b,
                                       input logic [7:0] c);
    logic [9:0] sum4;
    logic [8:0] total;
    sum4  = {2'b00, l} + {2'b00, t} + {2'b00, r} + {2'b00, b};
    total = {1'b0, sum4[9:2]} + {1'b0, c};
    return total[8:1];
  endfunction

endpackage

// ----- rtl/cfps_ram.sv -----
module cfps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // write port, registered read with new data on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/clamped_five_point_smoother.sv -----
// Five-point cross smoother over a raster height map with clamped edges.
// Sample channel (sample_valid/sample_ready/sample): pixel beats carry the
// map in raster order; drain beats release the last row after the frame.
// Result channel (result_valid/result_ready/result): one filtered cell per
// beat in raster order, frame_end set on the last cell of the map.
// The first row gives no results; each later pixel releases the cell above
// it, and each drain beat one cell of the last row. Drain beats before the
// frame is complete, and pixels while the last row is pending, are dropped.
// Latency: a result is on the result port the cycle after its sample beat.
// Throughput: one beat per cycle unless stalled; the window values come
// from the line stores, whose registered reads are addressed one step ahead.
// The result register frees in the same cycle it is taken, so sample_ready
// stays high while result_ready is high; when the receiver stalls with a
// result held, sample_ready drops until it is taken.
// Reset clears the counters and the result valid; the line stores are not
// cleared, as the first row fills them before any read.
module clamped_five_point_smoother (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_ready,
  input  cfps_pkg::sample_t  sample,
  output logic               result_valid,
  input  logic               result_ready,
  output cfps_pkg::result_t  result
);

  localparam int W = cfps_pkg::ColW;

  logic [W-1:0]                col, col_next;
  logic [W-1:0]                drain, drain_next;
  logic [cfps_pkg::RowW-1:0]   rows, rows_next;
  logic [7:0]                  left_hold, left_hold_next;
  logic [W-1:0]                idx, idx_next, idx_right;
  logic                        accept, draining, at_last, emit;
  logic                        wr_en;
  logic [7:0]                  wr_upper;
  logic [7:0]                  ctr, rgt_raw, top;
  logic [7:0]                  lft, rgt, bot;
  cfps_pkg::result_t           res_next;

  assign accept       = sample_valid && sample_ready;
  assign sample_ready = !result_valid || result_ready;
  assign draining     = (rows == cfps_pkg::RowW'(cfps_pkg::MapHeight));
  assign idx          = draining ? drain : col;
  assign at_last      = (idx == W'(cfps_pkg::MapWidth - 1));

  // window around the current index
  assign lft = (idx == '0) ? ctr : left_hold;
  assign rgt = at_last ? ctr : rgt_raw;
  assign bot = draining ? ctr : sample.pixel_value;

  // counter and write control
  always_comb begin
    col_next       = col;
    drain_next     = drain;
    rows_next      = rows;
    left_hold_next = left_hold;
    wr_en          = 1'b0;
    wr_upper       = sample.pixel_value;
    emit           = 1'b0;
    if (accept) begin
      case (sample.kind)
        cfps_pkg::KIND_PIXEL: begin
          if (!draining) begin
            wr_en = 1'b1;
            if (rows != '0) begin
              wr_upper       = ctr;
              emit           = 1'b1;
              left_hold_next = ctr;
            end
            if (at_last) begin
              col_next  = '0;
              rows_next = rows + 1'b1;
            end else begin
              col_next = col + 1'b1;
            end
          end
        end
        cfps_pkg::KIND_DRAIN: begin
          if (draining) begin
            emit           = 1'b1;
            left_hold_next = ctr;
            if (at_last) begin
              drain_next = '0;
              rows_next  = '0;
              col_next   = '0;
            end else begin
              drain_next = drain + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // read addresses one step ahead of the counters
  always_comb begin
    if (rst) begin
      idx_next = '0;
    end else if (rows_next == cfps_pkg::RowW'(cfps_pkg::MapHeight)) begin
      idx_next = drain_next;
    end else begin
      idx_next = col_next;
    end
    idx_right = (idx_next == W'(cfps_pkg::MapWidth - 1)) ? '0 : idx_next + 1'b1;
  end

  // result payload
  always_comb begin
    res_next.smoothed_value = cfps_pkg::blend(lft, top, rgt, bot, ctr);
    res_next.frame_end      = draining && at_last;
  end

  // line stores: middle row held twice for the centre and right reads
  cfps_ram #(.Width(8), .Depth(cfps_pkg::MapWidth)) u_middle_ctr (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col),
    .wr_data (sample.pixel_value),
    .rd_addr (idx_next),
    .rd_data (ctr)
  );

  cfps_ram #(.Width(8), .Depth(cfps_pkg::MapWidth)) u_middle_rgt (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col),
    .wr_data (sample.pixel_value),
    .rd_addr (idx_right),
    .rd_data (rgt_raw)
  );

  cfps_ram #(.Width(8), .Depth(cfps_pkg::MapWidth)) u_upper (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (col),
    .wr_data (wr_upper),
    .rd_addr (idx_next),
    .rd_data (top)
  );

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= '0;
      drain     <= '0;
      rows      <= '0;
      left_hold <= '0;
    end else begin
      col       <= col_next;
      drain     <= drain_next;
      rows      <= rows_next;
      left_hold <= left_hold_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= res_next;
    end
  end

endmodule
